### rtl/lvs_pkg.sv
package lvs_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SUM_W   = TIME_W + 1;
  localparam int unsigned VOL_W   = 48;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CA_W    = 2 * CFG_W;
  localparam int unsigned RAD_W   = 54;
  localparam int unsigned ROOT_W  = RAD_W / 2;
  localparam int unsigned FRAC_SH = 20;
  localparam int unsigned RVOL_W  = 2 * TIME_W - FRAC_SH;
  localparam int unsigned PROD_W  = CFG_W + ROOT_W;
  localparam int unsigned ACC_W   = PROD_W + 2;

  localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_RATE = 2'd1;
  localparam logic [1:0] CFG_COEF = 2'd2;
  localparam logic [1:0] CFG_AREA = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_RATE   = 2'd1,
    MODE_CARTER = 2'd2,
    MODE_ROOT   = 2'd3
  } lvs_mode_e;

  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_NONE,
    KIND_RATE,
    KIND_CARTER,
    KIND_ROOT
  } lvs_kind_e;

  typedef struct packed {
    lvs_mode_e        mode;
    logic [CFG_W-1:0] rate;
    logic [CFG_W-1:0] coef;
    logic [CFG_W-1:0] area;
  } lvs_cfg_t;

  typedef struct packed {
    lvs_kind_e         kind;
    logic [TIME_W-1:0] rad_a;
    logic [SUM_W-1:0]  rad_b;
    logic [RVOL_W-1:0] rate_vol;
    logic [VOL_W-1:0]  prior;
  } lvs_item_t;

  typedef struct packed {
    lvs_kind_e         kind;
    logic [RVOL_W-1:0] rate_vol;
    logic [VOL_W-1:0]  prior;
  } lvs_side_t;

endpackage

### rtl/lvs_fifo.sv
module lvs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != FULL);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### rtl/lvs_sqrt.sv
module lvs_sqrt #(
  parameter int unsigned RAD_W = 54
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [RAD_W-1:0]     rad_i,
  output logic [RAD_W/2-1:0]   root_o
);

  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 2;

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];

  // one root bit per stage, restoring
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W-1:0]  rem_in, rem_sh, trial;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? rem_sh - trial : rem_sh;
        root_q[i] <= {root_in[ROOT_W-2:0], ge};
        rad_q[i]  <= {rad_in[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

### rtl/lvs_front.sv
module lvs_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lvs_pkg::lvs_cfg_t         cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [lvs_pkg::TIME_W-1:0] time_now_i,
  input  logic [lvs_pkg::TIME_W-1:0] step_length_i,
  input  logic [lvs_pkg::VOL_W-1:0]  prior_volume_i,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output lvs_pkg::lvs_item_t        item_o
);

  import lvs_pkg::*;

  logic               vld_q, vld_d;
  lvs_item_t          item_q, item_d;
  logic [2*TIME_W-1:0] rate_prod;
  logic               take;

  assign in_ready_o   = !vld_q || push_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign push_valid_o = vld_q;
  assign item_o       = item_q;
  assign rate_prod    = cfg_i.rate * step_length_i;

  always_comb begin
    item_d.prior    = prior_volume_i;
    item_d.rate_vol = rate_prod[2*TIME_W-1:FRAC_SH];
    item_d.rad_a    = time_now_i;
    item_d.rad_b    = SUM_W'(time_now_i) + SUM_W'(step_length_i);
    case (cfg_i.mode)
      MODE_NONE:   item_d.kind = KIND_NONE;
      MODE_RATE:   item_d.kind = KIND_RATE;
      MODE_CARTER: item_d.kind = KIND_CARTER;
      MODE_ROOT: begin
        item_d.kind  = KIND_ROOT;
        item_d.rad_b = SUM_W'(step_length_i);
      end
      default:     item_d.kind = KIND_NONE;
    endcase
    if (step_length_i == '0) begin
      item_d.kind = KIND_ZERO;
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (push_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

### rtl/lvs_back.sv
module lvs_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lvs_pkg::lvs_cfg_t         cfg_i,
  input  logic                      pop_valid_i,
  output logic                      pop_ready_o,
  input  lvs_pkg::lvs_item_t        item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lvs_pkg::VOL_W-1:0] added_volume_o,
  output logic [lvs_pkg::VOL_W-1:0] total_volume_o,
  output logic [1:0]                status_o
);

  import lvs_pkg::*;

  logic               adv;
  logic [CA_W-1:0]    ca_q;
  logic [ROOT_W-1:0]  root_a, root_b;

  logic               dl_vld_q [ROOT_W];
  lvs_side_t          dl_q     [ROOT_W];

  logic               m1_vld_q, m2_vld_q, m3_vld_q, out_vld_q;
  lvs_side_t          m1_q, m2_q;
  logic [ROOT_W-1:0]  d_q, d_d;
  logic [PROD_W-1:0]  plo_q, phi_q;
  logic [ACC_W-1:0]   acc;
  lvs_kind_e          m3_kind_q;
  logic [VOL_W-1:0]   m3_prior_q, added_q, added_d;
  logic               sat_q, sat_d;
  logic [VOL_W:0]     total_sum;
  logic [VOL_W-1:0]   add_o_q, tot_o_q;
  logic [1:0]         stat_o_q, stat_d;

  assign adv         = !out_vld_q || out_ready_i;
  assign pop_ready_o = adv;

  always_ff @(posedge clk_i) begin
    ca_q <= cfg_i.coef * cfg_i.area;
  end

  lvs_sqrt #(.RAD_W(RAD_W)) u_sqrt_a (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  ({2'b00, item_i.rad_a, FRAC_SH'(0)}),
    .root_o (root_a)
  );

  lvs_sqrt #(.RAD_W(RAD_W)) u_sqrt_b (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  ({1'b0, item_i.rad_b, FRAC_SH'(0)}),
    .root_o (root_b)
  );

  // side data follows the root stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROOT_W; i++) begin
        dl_vld_q[i] <= 1'b0;
      end
      m1_vld_q  <= 1'b0;
      m2_vld_q  <= 1'b0;
      m3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      dl_vld_q[0] <= pop_valid_i;
      for (int i = 1; i < ROOT_W; i++) begin
        dl_vld_q[i] <= dl_vld_q[i-1];
      end
      m1_vld_q  <= dl_vld_q[ROOT_W-1];
      m2_vld_q  <= m1_vld_q;
      m3_vld_q  <= m2_vld_q;
      out_vld_q <= m3_vld_q;
    end
  end

  always_comb begin
    d_d = root_b;
    if (dl_q[ROOT_W-1].kind == KIND_CARTER) begin
      d_d = (root_b > root_a) ? root_b - root_a : '0;
    end
  end

  always_comb begin
    if (m2_q.kind == KIND_CARTER) begin
      acc = {1'b0, phi_q, 1'b0} + ACC_W'(plo_q[PROD_W-1:CFG_W-1]);
    end else begin
      acc = ACC_W'(phi_q) + ACC_W'(plo_q[PROD_W-1:CFG_W]);
    end
    sat_d   = 1'b0;
    added_d = '0;
    case (m2_q.kind)
      KIND_RATE: added_d = VOL_W'(m2_q.rate_vol);
      KIND_CARTER, KIND_ROOT: begin
        if (acc > ACC_W'(VOL_MAX)) begin
          added_d = VOL_MAX;
          sat_d   = 1'b1;
        end else begin
          added_d = acc[VOL_W-1:0];
        end
      end
      default: added_d = '0;
    endcase
  end

  assign total_sum = {1'b0, m3_prior_q} + {1'b0, added_q};

  always_comb begin
    if (m3_kind_q == KIND_ZERO) begin
      stat_d = STAT_ZERO;
    end else if (sat_q || total_sum[VOL_W]) begin
      stat_d = STAT_SAT;
    end else begin
      stat_d = STAT_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_q[0].kind     <= item_i.kind;
      dl_q[0].rate_vol <= item_i.rate_vol;
      dl_q[0].prior    <= item_i.prior;
      for (int i = 1; i < ROOT_W; i++) begin
        dl_q[i] <= dl_q[i-1];
      end
      m1_q       <= dl_q[ROOT_W-1];
      d_q        <= d_d;
      m2_q       <= m1_q;
      plo_q      <= ca_q[CFG_W-1:0] * d_q;
      phi_q      <= ca_q[CA_W-1:CFG_W] * d_q;
      m3_kind_q  <= m2_q.kind;
      m3_prior_q <= m2_q.prior;
      added_q    <= added_d;
      sat_q      <= sat_d;
      add_o_q    <= added_q;
      tot_o_q    <= total_sum[VOL_W] ? VOL_MAX : total_sum[VOL_W-1:0];
      stat_o_q   <= stat_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign added_volume_o = add_o_q;
  assign total_volume_o = tot_o_q;
  assign status_o       = stat_o_q;

  a_zero_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (stat_o_q == STAT_ZERO) |-> (add_o_q == '0))
    else $error("zero step with nonzero increment");

  a_total_ge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (stat_o_q != STAT_SAT) |-> (tot_o_q >= add_o_q))
    else $error("total below increment");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (stat_o_q == STAT_SAT) |-> (add_o_q == VOL_MAX) || (tot_o_q == VOL_MAX))
    else $error("saturation without a clamped value");

endmodule

### rtl/leakoff_volume_step.sv
// channel   | dir | tdata fields, lsb first
// s_axis    | in  | time_now[31:0], step_length[63:32], prior_volume[111:64]
// m_axis    | out | added_volume[47:0], total_volume[95:48], status[97:96], zero pad
// cfg       | in  | cfg_idx_i selects register, cfg_data_i written when cfg_we_i
//
// one transaction per cycle sustained while the output is not stalled
// data passes front register, queue, 27-stage square root pipeline and 4 back stages
// reset clears control state and the configuration registers, no clearing pass
// an output stall holds the back pipeline; the queue of QUEUE_DEPTH entries
// keeps the input side open until it fills
module leakoff_volume_step #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,   // time_now, step_length, prior_volume
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata    // added_volume, total_volume, status, pad
);

  import lvs_pkg::*;

  lvs_cfg_t         cfg_q;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  lvs_item_t        push_item, pop_item;
  logic [VOL_W-1:0] added_volume, total_volume;
  logic [1:0]       status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= MODE_NONE;
      cfg_q.rate <= '0;
      cfg_q.coef <= '0;
      cfg_q.area <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE: cfg_q.mode <= lvs_mode_e'(cfg_data_i[1:0]);
        CFG_RATE: cfg_q.rate <= cfg_data_i;
        CFG_COEF: cfg_q.coef <= cfg_data_i;
        CFG_AREA: cfg_q.area <= cfg_data_i;
        default:  cfg_q.mode <= cfg_q.mode;
      endcase
    end
  end

  lvs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .time_now_i     (s_axis_tdata[31:0]),
    .step_length_i  (s_axis_tdata[63:32]),
    .prior_volume_i (s_axis_tdata[111:64]),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .item_o         (push_item)
  );

  lvs_fifo #(
    .WIDTH ($bits(lvs_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_item),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_item)
  );

  lvs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .item_i         (pop_item),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .added_volume_o (added_volume),
    .total_volume_o (total_volume),
    .status_o       (status)
  );

  assign m_axis_tdata = {6'b0, status, total_volume, added_volume};

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import lvs_pkg::*;

  localparam int unsigned CARTER_SH = 31;
  localparam int unsigned ROOT_SH   = 32;

  typedef struct {
    logic [VOL_W-1:0] added;
    logic [VOL_W-1:0] total;
    logic [1:0]       status;
  } vol_result_t;

  class volume_scoreboard;
    lvs_cfg_t    regs;
    vol_result_t pending_volumes[$];
    int          errors;

    function new();
      regs = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_MODE: regs.mode = lvs_mode_e'(val[1:0]);
        CFG_RATE: regs.rate = val;
        CFG_COEF: regs.coef = val;
        default: regs.area = val;
      endcase
    endfunction

    // floor(sqrt(t * 2^20)): Q.12 time to Q.16 root
    function logic [26:0] root_q16(logic [32:0] t_q12);
      logic [63:0] rad;
      logic [63:0] trial;
      logic [26:0] r;
      rad = {11'd0, t_q12, 20'd0};
      r = '0;
      for (int b = 26; b >= 0; b--) begin
        trial = {37'd0, r} | (64'd1 << b);
        if (trial * trial <= rad) r = trial[26:0];
      end
      return r;
    endfunction

    function vol_result_t leaked_volume(logic [31:0] t, logic [31:0] dt,
                                        logic [47:0] pv);
      vol_result_t res;
      logic [127:0] ca;
      logic [127:0] inc;
      logic [26:0]  r0;
      logic [26:0]  r1;
      logic [26:0]  diff;
      logic [48:0]  sum;
      bit           sat;
      if (dt == '0) begin
        res.added = '0;
        res.total = pv;
        res.status = STAT_ZERO;
        return res;
      end
      sat = 1'b0;
      inc = '0;
      ca = 128'(regs.coef) * 128'(regs.area);
      case (regs.mode)
        MODE_RATE: inc = (128'(regs.rate) * 128'(dt)) >> FRAC_SH;
        MODE_CARTER: begin
          r0 = root_q16(33'(t));
          r1 = root_q16(33'(t) + 33'(dt));
          diff = (r1 > r0) ? r1 - r0 : '0;
          inc = (ca * 128'(diff)) >> CARTER_SH;
        end
        MODE_ROOT: inc = (ca * 128'(root_q16(33'(dt)))) >> ROOT_SH;
        default: inc = '0;
      endcase
      if (inc > 128'(VOL_MAX)) begin
        res.added = VOL_MAX;
        sat = 1'b1;
      end else begin
        res.added = inc[47:0];
      end
      sum = {1'b0, pv} + {1'b0, res.added};
      if (sum[48]) begin
        res.total = VOL_MAX;
        sat = 1'b1;
      end else begin
        res.total = sum[47:0];
      end
      res.status = sat ? STAT_SAT : STAT_OK;
      return res;
    endfunction

    function void note_step(logic [31:0] t, logic [31:0] dt, logic [47:0] pv);
      pending_volumes.push_back(leaked_volume(t, dt, pv));
    endfunction

    function int pending();
      return pending_volumes.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [103:0] data);
      vol_result_t want;
      if (pending_volumes.size() == 0) begin
        report($sformatf("transaction %h with nothing expected", data));
        return;
      end
      want = pending_volumes.pop_front();
      if (data[47:0] !== want.added)
        report($sformatf("added_volume %h, expected %h", data[47:0], want.added));
      if (data[95:48] !== want.total)
        report($sformatf("total_volume %h, expected %h", data[95:48], want.total));
      if (data[97:96] !== want.status)
        report($sformatf("status %0d, expected %0d", data[97:96], want.status));
    endtask
  endclass

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;

  int src_idle_pct = 13;
  int sink_stall_pct = 46;

  volume_scoreboard board = new();

  leakoff_volume_step u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    board.set_reg(idx, val);
  endtask

  task automatic load_setting(input lvs_mode_e mode, input logic [31:0] rate,
                              input logic [31:0] coef, input logic [31:0] area,
                              input bit junk_high);
    logic [31:0] mode_word;
    mode_word = junk_high ? ((32'($urandom) & ~32'd3) | 32'(mode)) : 32'(mode);
    write_reg(CFG_MODE, mode_word);
    write_reg(CFG_RATE, rate);
    write_reg(CFG_COEF, coef);
    write_reg(CFG_AREA, area);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_step(input logic [31:0] t, input logic [31:0] dt,
                           input logic [47:0] pv);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pv, dt, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_step(t, dt, pv);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_reg();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(7))
      0: return 32'hFFFF_FFFF - $urandom_range(15);
      1: return $urandom;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    if ($urandom_range(15) == 0) return 32'd0;
    return pick_time();
  endfunction

  function automatic logic [47:0] pick_volume();
    logic [47:0] v;
    v = {16'($urandom), 32'($urandom)};
    case ($urandom_range(3))
      0: return VOL_MAX - 48'($urandom_range(1000));
      1: return v;
      default: return v >> $urandom_range(47);
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers still at reset values: no leakoff
    send_step(32'd0, 32'd0, 48'd0);
    send_step(32'hFFFF_FFFF, 32'hFFFF_FFFF, VOL_MAX);
    send_step(32'd0, 32'd1, 48'd0);
    wait_idle();

    load_setting(MODE_RATE, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
    send_step(32'd0, 32'hFFFF_FFFF, 48'd0);
    send_step(32'd123, 32'hFFFF_FFFF, VOL_MAX);
    send_step(32'd5, 32'd0, VOL_MAX - 48'd1);
    send_step(32'd0, 32'd1, 48'd1);
    wait_idle();

    load_setting(MODE_CARTER, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_step(32'd0, 32'd1, 48'd0);
    send_step(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd0);
    send_step(32'hFFFF_FFFF, 32'd1, 48'd0);
    send_step(32'd0, 32'd0, 48'd123);
    wait_idle();

    load_setting(MODE_CARTER, 32'd0, 32'd1, 32'd1, 1'b0);
    send_step(32'd0, 32'hFFFF_FFFF, VOL_MAX);
    send_step(32'd1000, 32'd1, 48'd0);
    wait_idle();

    load_setting(MODE_ROOT, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_step(32'd0, 32'hFFFF_FFFF, 48'd0);
    send_step(32'd0, 32'd1, 48'd0);
    wait_idle();

    // unit coefficient and area
    load_setting(MODE_ROOT, 32'd0, 32'h0100_0000, 32'h0000_0100, 1'b0);
    send_step(32'd0, 32'h0000_1000, 48'd0);
    send_step(32'd0, 32'd1, VOL_MAX - 48'd5);
    wait_idle();

    load_setting(MODE_CARTER, 32'd0, 32'h0100_0000, 32'h0000_0100, 1'b0);
    send_step(32'd0, 32'h0000_4000, 48'd0);
    send_step(32'h0000_1000, 32'h0000_3000, 48'd0);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      src_idle_pct = (ph < 4) ? 13 : (ph < 8) ? 46 : 0;
      sink_stall_pct = (ph < 4) ? 46 : (ph < 8) ? 13 : 0;
      load_setting(lvs_mode_e'(ph % 4), pick_reg(), pick_reg(), pick_reg(), 1'b1);
      repeat (66) send_step(pick_time(), pick_step(), pick_volume());
      wait_idle();
    end

    repeat (64) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### leakoff_volume_step.f
rtl/lvs_pkg.sv
rtl/lvs_fifo.sv
rtl/lvs_sqrt.sv
rtl/lvs_front.sv
rtl/lvs_back.sv
rtl/leakoff_volume_step.sv
sim/tb_top.sv
